// ===== hdl/ffas_pkg.sv =====
// ----------------------------------------------------------------------------
// ffas_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package ffas_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int CUR_W       = 34;
   localparam int DVD_W       = 33;
   localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_BIG   = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_IDX_INC,
      OP_IDX_DEC,
      OP_CUR_END,
      OP_DIV_STEP,
      OP_ROUND,
      OP_PLACE_GAP,
      OP_PLACE_TAIL,
      OP_COMMIT_ALLOC,
      OP_COMMIT_FREE,
      OP_COUNT_DEC,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_IDX_M1,
      RA_IDX_P1
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_MOVE,
      WR_NEW
   } wr_sel_type;

   typedef struct packed {
      dp_op_type  op;
      logic       mem_rd;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       st_wr;
      logic [2:0] st;
   } ffas_cmd_type;

   typedef struct packed {
      logic is_free;
      logic too_big;
      logic full;
      logic empty;
      logic idx_lt_count;
      logic idx_gt_slot;
      logic idx_next_lt_count;
      logic gap_fits;
      logic tail_fits;
      logic match;
      logic div_last;
      logic out_free;
   } ffas_status_type;

endpackage

// ===== hdl/ffas_datapath.sv =====
// ----------------------------------------------------------------------------
// ffas_datapath
// region table memory, scan cursor, remainder unit and result register
// ----------------------------------------------------------------------------
module ffas_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  ffas_pkg::ffas_cmd_type   cmd,
   output ffas_pkg::ffas_status_type sts,
   input  logic                     req_type,
   input  logic [31:0]              req_size,
   input  logic [31:0]              req_alignment,
   input  logic [31:0]              req_free_offset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [31:0]              csr_total_size,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [31:0]              rsp_alloc_offset,
   output logic [31:0]              rsp_free_bytes
);
   import ffas_pkg::*;

   logic [63:0]       mem_ff [MAX_REGIONS];
   logic [63:0]       rdata_ff;
   logic [31:0]       total_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       used_ff, used_in;
   logic              type_ff;
   logic [31:0]       size_ff, align_ff, foff_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [31:0]       where_ff, where_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [2:0]        st_ff;
   logic [31:0]       off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_off_ff, rsp_free_ff;

   logic [31:0]       rd_start, rd_len;
   logic [CUR_W-1:0]  s_ext, tot_ext, size_ext;
   logic [32:0]       end_sum, add_sum, trial;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [CNT_W-1:0]  rd_addr_full;
   logic [31:0]       len_lat;

   assign rd_start = rdata_ff[63:32];
   assign rd_len   = rdata_ff[31:0];
   assign s_ext    = {2'b00, rd_start};
   assign tot_ext  = {2'b00, total_ff};
   assign size_ext = {2'b00, size_ff};
   assign end_sum  = {1'b0, rd_start} + {1'b0, rd_len};
   assign add_sum  = {1'b0, used_ff} + {1'b0, size_ff};
   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign len_lat  = rd_len;
   assign csr_ready = 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         RA_IDX_M1: rd_addr_full = idx_ff - CNT_W'(1);
         RA_IDX_P1: rd_addr_full = idx_ff + CNT_W'(1);
         default:   rd_addr_full = idx_ff;
      endcase
   end
   assign rd_addr = rd_addr_full[IDX_W-1:0];
   assign wr_addr = (cmd.wr_sel == WR_NEW) ? slot_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_comb begin
      sts.is_free           = type_ff;
      sts.too_big           = size_ff > total_ff;
      sts.full              = count_ff >= CNT_W'(MAX_REGIONS);
      sts.empty             = count_ff == '0;
      sts.idx_lt_count      = idx_ff < count_ff;
      sts.idx_gt_slot       = idx_ff > slot_ff;
      sts.idx_next_lt_count = (idx_ff + CNT_W'(1)) < count_ff;
      sts.gap_fits          = (cur_ff < s_ext) && ((s_ext - cur_ff) >= size_ext);
      sts.tail_fits         = (tot_ext > cur_ff) && ((tot_ext - cur_ff) >= size_ext);
      sts.match             = rd_start == foff_ff;
      sts.div_last          = dcnt_ff == DIV_CNT_W'(1);
      sts.out_free          = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      used_in  = used_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      cur_in   = cur_ff;
      where_in = where_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      off_in   = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         OP_LOAD: begin
            idx_in = '0;
            cur_in = '0;
            off_in = '0;
         end
         OP_IDX_INC: idx_in = idx_ff + CNT_W'(1);
         OP_IDX_DEC: idx_in = idx_ff - CNT_W'(1);
         OP_CUR_END: begin
            cur_in  = {1'b0, end_sum};
            dvd_in  = end_sum;
            rem_in  = '0;
            dcnt_in = DIV_CNT_W'(DVD_W);
         end
         OP_DIV_STEP: begin
            dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
            dcnt_in = dcnt_ff - DIV_CNT_W'(1);
            if (trial >= {1'b0, align_ff}) begin
               rem_in = 32'(trial - {1'b0, align_ff});
            end else begin
               rem_in = trial[31:0];
            end
         end
         OP_ROUND: begin
            idx_in = idx_ff + CNT_W'(1);
            if (rem_ff != '0) begin
               cur_in = cur_ff + {2'b00, align_ff - rem_ff};
            end
         end
         OP_PLACE_GAP: begin
            where_in = cur_ff[31:0];
            slot_in  = idx_ff;
            idx_in   = count_ff;
         end
         OP_PLACE_TAIL: begin
            where_in = cur_ff[31:0];
            slot_in  = count_ff;
            idx_in   = count_ff;
         end
         OP_COMMIT_ALLOC: begin
            count_in = count_ff + CNT_W'(1);
            used_in  = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
            off_in   = where_ff;
         end
         OP_COMMIT_FREE: used_in = (len_lat > used_ff) ? '0 : used_ff - len_lat;
         OP_COUNT_DEC:   count_in = count_ff - CNT_W'(1);
         OP_RESULT:      rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            total_ff <= csr_total_size;
         end
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      slot_ff  <= slot_in;
      cur_ff   <= cur_in;
      where_ff <= where_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      off_ff   <= off_in;
      if (cmd.op == OP_LOAD) begin
         type_ff  <= req_type;
         size_ff  <= req_size;
         align_ff <= (req_alignment == '0) ? 32'd1 : req_alignment;
         foff_ff  <= req_free_offset;
      end
      if (cmd.st_wr) begin
         st_ff <= cmd.st;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_status_ff <= st_ff;
         rsp_off_ff    <= off_ff;
         rsp_free_ff   <= (used_ff > total_ff) ? '0 : total_ff - used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem_ff[rd_addr];
      end
      case (cmd.wr_sel)
         WR_MOVE: mem_ff[wr_addr] <= rdata_ff;
         WR_NEW:  mem_ff[wr_addr] <= {where_ff, size_ff};
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_off_ff;
   assign rsp_free_bytes   = rsp_free_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("region count above table depth");
   a_result_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> rsp_valid_ff)
      else $error("result load did not raise valid");
   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel != WR_NONE) |-> (wr_addr <= count_ff))
      else $error("table write past live entries");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(cmd.op) == OP_COMMIT_ALLOC
         || $past(cmd.op) == OP_COUNT_DEC))
      else $error("region count changed without commit");

endmodule

// ===== hdl/ffas_controller.sv =====
// ----------------------------------------------------------------------------
// ffas_controller
// sequencer for allocate and free scans, remainder steps, table shifts and result
// ----------------------------------------------------------------------------
module ffas_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ffas_pkg::ffas_status_type sts,
   output ffas_pkg::ffas_cmd_type    cmd
);
   import ffas_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_A_RD,
      S_A_EVAL,
      S_A_DIV,
      S_A_ROUND,
      S_A_NEXT,
      S_A_TAIL,
      S_A_SHIFT,
      S_A_SHW,
      S_A_INS,
      S_F_CHK,
      S_F_EVAL,
      S_F_SH,
      S_F_SHW,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '{op: OP_NOP, mem_rd: 1'b0, rd_sel: RA_IDX, wr_sel: WR_NONE,
                   st_wr: 1'b0, st: ST_OK};
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_free) begin
               state_in = S_F_CHK;
            end else if (sts.too_big) begin
               cmd.st_wr = 1'b1;
               cmd.st    = ST_TOO_BIG;
               state_in  = S_FIN;
            end else if (sts.full) begin
               cmd.st_wr = 1'b1;
               cmd.st    = ST_FULL;
               state_in  = S_FIN;
            end else if (sts.empty) begin
               cmd.op   = OP_PLACE_TAIL;
               state_in = S_A_SHIFT;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_A_EVAL;
         end
         S_A_EVAL: begin
            if (sts.gap_fits) begin
               cmd.op   = OP_PLACE_GAP;
               state_in = S_A_SHIFT;
            end else begin
               cmd.op   = OP_CUR_END;
               state_in = S_A_DIV;
            end
         end
         S_A_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = S_A_ROUND;
            end
         end
         S_A_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_A_NEXT;
         end
         S_A_NEXT: begin
            state_in = sts.idx_lt_count ? S_A_RD : S_A_TAIL;
         end
         S_A_TAIL: begin
            if (sts.tail_fits) begin
               cmd.op   = OP_PLACE_TAIL;
               state_in = S_A_SHIFT;
            end else begin
               cmd.st_wr = 1'b1;
               cmd.st    = ST_NO_SPACE;
               state_in  = S_FIN;
            end
         end
         S_A_SHIFT: begin
            if (sts.idx_gt_slot) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RA_IDX_M1;
               state_in   = S_A_SHW;
            end else begin
               state_in = S_A_INS;
            end
         end
         S_A_SHW: begin
            cmd.wr_sel = WR_MOVE;
            cmd.op     = OP_IDX_DEC;
            state_in   = S_A_SHIFT;
         end
         S_A_INS: begin
            cmd.wr_sel = WR_NEW;
            cmd.op     = OP_COMMIT_ALLOC;
            cmd.st_wr  = 1'b1;
            cmd.st     = ST_OK;
            state_in   = S_FIN;
         end
         S_F_CHK: begin
            if (sts.idx_lt_count) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_F_EVAL;
            end else begin
               cmd.st_wr = 1'b1;
               cmd.st    = ST_NOT_FOUND;
               state_in  = S_FIN;
            end
         end
         S_F_EVAL: begin
            if (sts.match) begin
               cmd.op   = OP_COMMIT_FREE;
               state_in = S_F_SH;
            end else begin
               cmd.op   = OP_IDX_INC;
               state_in = S_F_CHK;
            end
         end
         S_F_SH: begin
            if (sts.idx_next_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RA_IDX_P1;
               state_in   = S_F_SHW;
            end else begin
               cmd.op    = OP_COUNT_DEC;
               cmd.st_wr = 1'b1;
               cmd.st    = ST_OK;
               state_in  = S_FIN;
            end
         end
         S_F_SHW: begin
            cmd.wr_sel = WR_MOVE;
            cmd.op     = OP_IDX_INC;
            state_in   = S_F_SH;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> (state_ff == S_IDLE && req_valid))
      else $error("request latched outside idle");
   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> (state_ff == S_IDLE))
      else $error("result issued without return to idle");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && cmd.wr_sel != WR_NONE))
      else $error("table read and write in one cycle");

endmodule

// ===== hdl/first_fit_aligned_suballocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator_top
// first-fit suballocator over a sorted table of up to 64 live regions
// ----------------------------------------------------------------------------
// One word at a time. A free scans the table entries in turn, then shifts the
// later entries down. An allocate scans the entries in turn; for each entry
// whose gap is too small it runs a 33-step bit-serial remainder unit that
// rounds the region end up to the alignment, then it shifts entries up through
// the single table port. Too big and table full are found before any scan; no
// space and not found come only after the whole table is scanned. A finished
// word waits in the output register while the next request is taken.
// total_size is written through csr_; the user must do so only while idle,
// as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_aligned_suballocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_size,
   input  logic [31:0] req_alignment,
   input  logic [31:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_alloc_offset,
   output logic [31:0] rsp_free_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_total_size
);
   import ffas_pkg::*;

   ffas_cmd_type    cmd;
   ffas_status_type sts;

   ffas_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffas_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_size         (req_size),
      .req_alignment    (req_alignment),
      .req_free_offset  (req_free_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_total_size   (csr_total_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_alloc_offset (rsp_alloc_offset),
      .rsp_free_bytes   (rsp_free_bytes)
   );

endmodule

// ===== dv/tb_first_fit_aligned_suballocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_aligned_suballocator_top
// self-checking bench for the first-fit aligned suballocator
// ----------------------------------------------------------------------------
// A short table of directed words covers the corners: zero total size, empty
// table, zero size and zero alignment, a cursor pushed up to 2^32, duplicate
// starts and a memory shrunk below the used size. Random phases follow, each
// with its own total size and allocate/free mix, and some fill the table up.
// Every accepted word is run through a behavioral copy of the allocator, and
// each response is compared against the oldest expected word. The sender
// works in bursts, and the response side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_first_fit_aligned_suballocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ffas_pkg::*;

   localparam int         RAND_PHASES = 8;
   localparam int         PHASE_WORDS = 113;
   localparam longint     CYCLE_LIMIT = 12_000_000;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        is_csr;
      logic        is_free;
      logic [31:0] size;
      logic [31:0] align;
      logic [31:0] offset;
      logic        chk;
      logic [2:0]  status;
      logic [31:0] alloc_offset;
      logic [31:0] free_bytes;
   } stim_row_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] alloc_offset;
      logic [31:0] free_bytes;
   } rsp_word_type;

   localparam int NUM_ROWS = 20;
   localparam stim_row_type STIM [NUM_ROWS] = '{
      '{1'b1, REQ_ALLOC, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd1, 32'd1, 32'd0, 1'b1, ST_TOO_BIG, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd0, 32'd0, ALL_ONES, 1'b1, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, ALL_ONES, ALL_ONES, 32'd0, 1'b1, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, 32'd0, 32'd1, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 32'd0},
      '{1'b1, REQ_ALLOC, 32'd0, 32'd0, ALL_ONES, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, ALL_ONES, 32'd1, ALL_ONES, 1'b1, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd1, 32'h8000_0000, 32'd0, 1'b1, ST_NO_SPACE, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, 32'd0, 32'd1, 32'd0, 1'b1, ST_OK, 32'd0, ALL_ONES},
      '{1'b0, REQ_ALLOC, 32'd16, ALL_ONES, 32'd0, 1'b1, ST_OK, 32'd0, 32'hFFFF_FFEF},
      '{1'b0, REQ_ALLOC, 32'd16, 32'd64, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd0, 32'd1, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd0, 32'd1, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd20, 32'd3, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, 32'd0, 32'd1, 32'd16, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, 32'd0, 32'd1, 32'h1234_5678, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b1, REQ_ALLOC, 32'd0, 32'd0, 32'd40, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd0, 32'd1, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0},
      '{1'b0, REQ_ALLOC, 32'd41, 32'd1, 32'd0, 1'b1, ST_TOO_BIG, 32'd0, 32'd0},
      '{1'b0, REQ_FREE, 32'd0, 32'd1, 32'd0, 1'b0, ST_OK, 32'd0, 32'd0}
   };

   localparam logic [31:0] PHASE_TOTAL [RAND_PHASES] = '{
      32'd4096, 32'd1048576, ALL_ONES, 32'd300, 32'd65536, 32'd0, 32'd2048, ALL_ONES
   };
   localparam int PHASE_ALLOC_PCT [RAND_PHASES] = '{65, 92, 70, 60, 88, 50, 60, 80};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = REQ_ALLOC;
   logic [31:0] req_size = '0;
   logic [31:0] req_alignment = 32'd1;
   logic [31:0] req_free_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_alloc_offset;
   logic [31:0] rsp_free_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_total_size = '0;

   // allocator image
   logic [31:0] img_start [MAX_REGIONS];
   logic [31:0] img_len [MAX_REGIONS];
   int          img_count = 0;
   logic [31:0] img_used = '0;
   logic [31:0] img_total = '0;

   rsp_word_type pending_rsp [$];
   int          mismatches = 0;
   longint      cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   first_fit_aligned_suballocator_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_word_type suballoc_step(logic is_free, logic [31:0] size,
                                                  logic [31:0] align_in, logic [31:0] foff);
      rsp_word_type r;
      logic [63:0] cur, s, where, al;
      int          slot, i;
      bit          found;
      r = '0;
      r.status = ST_OK;
      al = (align_in == 0) ? 64'd1 : {32'd0, align_in};
      found = 1'b0;
      cur = '0;
      where = '0;
      slot = 0;
      if (is_free == REQ_ALLOC) begin
         if (size > img_total) begin
            r.status = ST_TOO_BIG;
         end else if (img_count >= MAX_REGIONS) begin
            r.status = ST_FULL;
         end else begin
            if (img_count == 0) found = 1'b1;
            for (i = 0; i < img_count && !found; i++) begin
               s = {32'd0, img_start[i]};
               if (cur < s && s - cur >= {32'd0, size}) begin
                  found = 1'b1;
                  where = cur;
                  slot = i;
               end else begin
                  cur = s + {32'd0, img_len[i]};
                  if (cur % al != 0) cur = (cur / al + 1) * al;
               end
            end
            if (!found && img_count != 0 && {32'd0, img_total} > cur
                && {32'd0, img_total} - cur >= {32'd0, size}) begin
               found = 1'b1;
               where = cur;
               slot = img_count;
            end
            if (!found) begin
               r.status = ST_NO_SPACE;
            end else begin
               for (i = img_count; i > slot; i--) begin
                  img_start[i] = img_start[i-1];
                  img_len[i] = img_len[i-1];
               end
               img_start[slot] = where[31:0];
               img_len[slot] = size;
               img_count++;
               img_used = (img_used > ALL_ONES - size) ? ALL_ONES : img_used + size;
               r.alloc_offset = where[31:0];
            end
         end
      end else begin
         r.status = ST_NOT_FOUND;
         for (i = 0; i < img_count && !found; i++) begin
            if (img_start[i] == foff) begin
               found = 1'b1;
               img_used = (img_len[i] > img_used) ? '0 : img_used - img_len[i];
               for (slot = i; slot + 1 < img_count; slot++) begin
                  img_start[slot] = img_start[slot+1];
                  img_len[slot] = img_len[slot+1];
               end
               img_count--;
               r.status = ST_OK;
            end
         end
      end
      r.free_bytes = (img_used > img_total) ? '0 : img_total - img_used;
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(logic is_free, logic [31:0] size, logic [31:0] align,
                            logic [31:0] foff, logic chk, rsp_word_type typed);
      rsp_word_type r;
      int        gap;
      req_valid = 1'b1;
      req_type = is_free;
      req_size = size;
      req_alignment = align;
      req_free_offset = foff;
      do @(posedge clock); while (req_stall);
      r = suballoc_step(is_free, size, align, foff);
      pending_rsp.push_back(chk ? typed : r);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_total(logic [31:0] value);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid = 1'b1;
      csr_total_size = value;
      do @(posedge clock); while (!csr_ready);
      img_total = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(100, 600);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      rsp_word_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_first_fit_aligned_suballocator_top: done, errors");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d offset %h free %h",
                        rsp_status, rsp_alloc_offset, rsp_free_bytes);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_alloc_offset !== want.alloc_offset
                || rsp_free_bytes !== want.free_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status %0d offset %h free %h, got %0d %h %h",
                           want.status, want.alloc_offset, want.free_bytes,
                           rsp_status, rsp_alloc_offset, rsp_free_bytes);
            end
         end
      end
   end

   initial begin
      logic        is_free;
      logic [31:0] size, align, foff, lim;
      int          pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (STIM[k]) begin
         if (STIM[k].is_csr)
            write_total(STIM[k].offset);
         else
            send_word(STIM[k].is_free, STIM[k].size, STIM[k].align, STIM[k].offset,
                      STIM[k].chk, '{STIM[k].status, STIM[k].alloc_offset,
                                     STIM[k].free_bytes});
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         write_total(PHASE_TOTAL[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            is_free = ($urandom_range(0, 99) < PHASE_ALLOC_PCT[p]) ? REQ_ALLOC : REQ_FREE;
            lim = img_total / 48;
            if (lim == 0) lim = 1;
            if (lim > 32'd1048576) lim = 32'd1048576;
            pick = $urandom_range(0, 99);
            size = (pick < 5) ? $urandom : (pick < 10) ? 32'd0 : $urandom_range(0, lim);
            pick = $urandom_range(0, 99);
            case (pick % 10)
               0: align = (pick < 50) ? $urandom : 32'd0;
               1: align = 32'd3;
               2: align = 32'd12;
               default: align = 32'd1 << $urandom_range(0, 6);
            endcase
            foff = $urandom;
            if (is_free == REQ_FREE && img_count > 0 && $urandom_range(0, 3) != 0)
               foff = img_start[$urandom_range(0, img_count - 1)];
            send_word(is_free, size, align, foff, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (mismatches == 0)
         $display("tb_first_fit_aligned_suballocator_top: done, clean");
      else
         $display("tb_first_fit_aligned_suballocator_top: done, errors");
      $finish;
   end

endmodule
